>>> sv/ppfd_pkg.sv
// Shared types and constants of the planar PackBits frame decoder.
`timescale 1ns / 1ps

package ppfd_pkg;

	// Decoder sequencing: header table, run data, row-length lookup, frame end.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_DATA,
		PH_SEEK_RD,
		PH_SEEK_CHK,
		PH_DONE
	} phase_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_PLANE_COUNT,
		REG_ROW_COUNT,
		REG_ROW_STRIDE,
		REG_PIXEL_BYTES
	} reg_index_t;

	localparam int CFG_W  = 15;
	localparam int ADDR_W = 24;
	localparam int LEN_W  = 16;

	// Control bytes up to this value start a literal run.
	localparam logic [7:0] LIT_MAX_CTRL = 8'd127;
	// A repeat control byte C repeats the next byte REP_BASE - C times.
	localparam logic [8:0] REP_BASE     = 9'd257;

endpackage

>>> sv/planar_packbits_frame_decoder.sv
// Planar PackBits frame decoder: header table capture, run decoding and run descriptors.
`timescale 1ns / 1ps

// Takes one compressed frame byte per request; s_tuser high marks the first byte of a
// frame. The header table of big-endian row lengths is stored in a 3*MAX_HEIGHT x 16
// synchronous memory (no reset, no clearing pass: every entry is written by the header
// before it is read). Header bytes and bytes inside a row are taken one per cycle while
// the output register can take a result. When a row ends, the input is held off while
// the row-length memory is consulted through its single read port: first the read is
// issued, then rows are examined one at a time (the next row, then each zero-length row skipped). Each
// result request carries a run descriptor: byte_address, pixel_value and fill_count in
// m_tdata, frame_done on m_tlast and length_error on m_tuser. Results sit in an output
// register, so a new byte is taken in the same cycle that a waiting result is taken.
module planar_packbits_frame_decoder #(
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Configuration write port.
	input  logic                     cfg_we,
	input  ppfd_pkg::reg_index_t     cfg_index,
	input  logic [ppfd_pkg::CFG_W-1:0] cfg_data,
	// Compressed byte stream.
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,   // [7:0] data_byte
	input  logic                     s_tuser,   // [0] frame_start
	// Run descriptors.
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [39:0]              m_tdata,   // [23:0] byte_address, [31:24] pixel_value,
	                                            // [39:32] fill_count
	output logic                     m_tlast,   // frame_done
	output logic                     m_tuser    // [0] length_error
);
	import ppfd_pkg::*;

	localparam int RW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DEPTH     = 3 * MAX_HEIGHT;
	localparam int AW        = $clog2(DEPTH);
	localparam logic [AW-1:0] PLANE1_BASE = AW'(MAX_HEIGHT);
	localparam logic [AW-1:0] PLANE2_BASE = AW'(2 * MAX_HEIGHT);
	localparam logic [16:0]   MAXH        = 17'(MAX_HEIGHT);

	// Configuration registers.
	logic [2:0]       plane_count_q;
	logic [10:0]      row_count_q;
	logic [CFG_W-1:0] row_stride_q;
	logic [2:0]       pixel_bytes_q;

	// Decoder state.
	phase_t              phase_q, phase_d;
	logic                hdr_odd_q, hdr_odd_d;
	logic [RW-1:0]       hdr_row_q, hdr_row_d;
	logic [1:0]          hdr_plane_q, hdr_plane_d;
	logic [7:0]          len_hi_q, len_hi_d;
	logic [1:0]          plane_q, plane_d;
	logic [RW-1:0]       row_q, row_d;
	logic [ADDR_W-1:0]   row_off_q, row_off_d;
	logic [ADDR_W-1:0]   wr_addr_q, wr_addr_d;
	logic [LEN_W-1:0]    row_left_q, row_left_d;
	logic [7:0]          lit_left_q, lit_left_d;
	logic [7:0]          pend_fill_q, pend_fill_d;

	// Result held back while the following rows are looked up.
	logic                held_emit_q, held_emit_d;
	logic [ADDR_W-1:0]   held_addr_q, held_addr_d;
	logic [7:0]          held_val_q, held_val_d;
	logic [7:0]          held_fill_q, held_fill_d;
	logic                held_err_q, held_err_d;

	// Output register.
	logic                out_vld_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [7:0]          out_val_q;
	logic [7:0]          out_fill_q;
	logic                out_done_q;
	logic                out_err_q;

	// Row-length memory.
	logic [LEN_W-1:0]    tbl_mem [DEPTH];
	logic [LEN_W-1:0]    rd_len_q;
	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_wa, mem_ra;
	logic [LEN_W-1:0]    mem_wd;

	// Derived configuration.
	logic [16:0]         rc_ext;
	logic [16:0]         last_row_ext;
	logic [RW-1:0]       last_row;
	logic [2:0]          stream_planes;
	logic [1:0]          last_splane;
	logic [1:0]          last_dplane;
	logic                single_plane;
	logic [ADDR_W-1:0]   channel;

	// Row advance.
	logic                adv_wrap;
	logic                adv_done;
	logic [RW-1:0]       adv_row;
	logic [1:0]          adv_plane;
	logic [ADDR_W-1:0]   adv_off;

	// Per-request working values.
	logic                acc;
	logic                can_emit;
	logic                h_odd;
	logic [RW-1:0]       h_row;
	logic [1:0]          h_plane;
	logic [7:0]          lit_n, pend_n;
	logic [LEN_W-1:0]    row_left_n;
	logic [8:0]          cost;
	logic [10:0]         rep_step;
	logic                e_emit, e_err;
	logic [ADDR_W-1:0]   e_addr;
	logic [7:0]          e_val, e_fill;
	logic                ld, ld_done, ld_err;
	logic [ADDR_W-1:0]   ld_addr;
	logic [7:0]          ld_val, ld_fill;

	// Table address of a plane and row.
	function automatic logic [AW-1:0] tbl_addr(input logic [1:0] p, input logic [RW-1:0] r);
		logic [AW-1:0] base;
		unique case (p)
			2'd1:    base = PLANE1_BASE;
			2'd2:    base = PLANE2_BASE;
			default: base = '0;
		endcase
		return base + AW'(r);
	endfunction

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q <= 3'd3;
			row_count_q   <= 11'd1;
			row_stride_q  <= 15'd3;
			pixel_bytes_q <= 3'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PLANE_COUNT: plane_count_q <= cfg_data[2:0];
				REG_ROW_COUNT:   row_count_q   <= cfg_data[10:0];
				REG_ROW_STRIDE:  row_stride_q  <= cfg_data[14:0];
				REG_PIXEL_BYTES: pixel_bytes_q <= cfg_data[2:0];
			endcase
		end
	end

	// Effective row count and plane counts.
	always_comb begin
		rc_ext = {6'b0, row_count_q};
		if (rc_ext == '0) begin
			last_row_ext = '0;
		end else if (rc_ext > MAXH) begin
			last_row_ext = MAXH - 17'd1;
		end else begin
			last_row_ext = rc_ext - 17'd1;
		end
		last_row = last_row_ext[RW-1:0];

		if (plane_count_q == 3'd0) begin
			stream_planes = 3'd1;
		end else if (plane_count_q > 3'd4) begin
			stream_planes = 3'd4;
		end else begin
			stream_planes = plane_count_q;
		end
		last_splane  = 2'(stream_planes - 3'd1);
		last_dplane  = (stream_planes > 3'd3) ? 2'd2 : last_splane;
		single_plane = (stream_planes == 3'd1);
		channel      = single_plane ? '0 : ADDR_W'(2'(2'd2 - plane_q));
	end

	// Step to the next row, and to the next plane after the last row.
	always_comb begin
		adv_wrap  = (row_q == last_row);
		adv_done  = adv_wrap && (plane_q == last_dplane);
		adv_row   = adv_wrap ? '0 : row_q + RW'(1);
		adv_plane = adv_wrap ? plane_q + 2'd1 : plane_q;
		adv_off   = adv_wrap ? '0 : row_off_q + ADDR_W'(row_stride_q);
	end

	assign can_emit = !out_vld_q || m_tready;
	assign s_tready = (phase_q != PH_SEEK_RD) && (phase_q != PH_SEEK_CHK) && can_emit;
	assign acc      = s_tvalid && s_tready;
	assign rep_step = {3'b0, pend_fill_q} * {8'b0, pixel_bytes_q};

	// Next state, table accesses and results.
	always_comb begin
		phase_d     = phase_q;
		hdr_odd_d   = hdr_odd_q;
		hdr_row_d   = hdr_row_q;
		hdr_plane_d = hdr_plane_q;
		len_hi_d    = len_hi_q;
		plane_d     = plane_q;
		row_d       = row_q;
		row_off_d   = row_off_q;
		wr_addr_d   = wr_addr_q;
		row_left_d  = row_left_q;
		lit_left_d  = lit_left_q;
		pend_fill_d = pend_fill_q;
		held_emit_d = held_emit_q;
		held_addr_d = held_addr_q;
		held_val_d  = held_val_q;
		held_fill_d = held_fill_q;
		held_err_d  = held_err_q;

		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = tbl_addr(plane_q, row_q);

		ld      = 1'b0;
		ld_addr = '0;
		ld_val  = '0;
		ld_fill = '0;
		ld_done = 1'b0;
		ld_err  = 1'b0;

		h_odd      = hdr_odd_q;
		h_row      = hdr_row_q;
		h_plane    = hdr_plane_q;
		lit_n      = lit_left_q;
		pend_n     = pend_fill_q;
		row_left_n = row_left_q;
		cost       = '0;
		e_emit     = 1'b0;
		e_err      = 1'b0;
		e_addr     = '0;
		e_val      = '0;
		e_fill     = '0;

		if (acc && (s_tuser || phase_q == PH_HEADER)) begin
			// Header table: a frame start restarts it at byte zero.
			if (s_tuser) begin
				h_odd       = 1'b0;
				h_row       = '0;
				h_plane     = '0;
				lit_left_d  = '0;
				pend_fill_d = '0;
			end
			phase_d     = PH_HEADER;
			hdr_odd_d   = !h_odd;
			hdr_row_d   = h_row;
			hdr_plane_d = h_plane;
			if (!h_odd) begin
				len_hi_d = s_tdata;
			end else begin
				mem_we = (h_plane != 2'd3);
				mem_wa = tbl_addr(h_plane, h_row);
				mem_wd = {len_hi_q, s_tdata};
				if (h_row == last_row) begin
					hdr_row_d   = '0;
					hdr_plane_d = h_plane + 2'd1;
					if (h_plane == last_splane) begin
						// Table complete: look up the first row.
						phase_d     = PH_SEEK_RD;
						plane_d     = '0;
						row_d       = '0;
						row_off_d   = '0;
						held_emit_d = 1'b0;
						held_addr_d = '0;
						held_val_d  = '0;
						held_fill_d = '0;
						held_err_d  = 1'b0;
					end
				end else begin
					hdr_row_d = h_row + RW'(1);
				end
			end
		end else if (acc && phase_q == PH_DATA) begin
			// Run data.
			if (lit_left_q != '0) begin
				e_emit    = 1'b1;
				e_addr    = wr_addr_q;
				e_val     = s_tdata;
				e_fill    = 8'd1;
				wr_addr_d = wr_addr_q + ADDR_W'(pixel_bytes_q);
				lit_n     = lit_left_q - 8'd1;
			end else if (pend_fill_q != '0) begin
				e_emit    = 1'b1;
				e_addr    = wr_addr_q;
				e_val     = s_tdata;
				e_fill    = pend_fill_q;
				wr_addr_d = wr_addr_q + ADDR_W'(rep_step);
				pend_n    = '0;
			end else begin
				if (s_tdata <= LIT_MAX_CTRL) begin
					lit_n = s_tdata + 8'd1;
					cost  = {1'b0, s_tdata} + 9'd2;
				end else begin
					pend_n = 8'(REP_BASE - {1'b0, s_tdata});
					cost   = 9'd2;
				end
				if ({7'b0, cost} > row_left_q) begin
					e_emit     = 1'b1;
					e_err      = 1'b1;
					row_left_n = '0;
				end else begin
					row_left_n = row_left_q - LEN_W'(cost);
				end
			end
			lit_left_d  = lit_n;
			pend_fill_d = pend_n;
			row_left_d  = row_left_n;

			if (lit_n == '0 && pend_n == '0 && row_left_n == '0) begin
				// Row finished: either the frame ends here or the next row is looked up.
				if (adv_done) begin
					phase_d = PH_DONE;
					ld      = 1'b1;
					ld_addr = e_addr;
					ld_val  = e_val;
					ld_fill = e_fill;
					ld_err  = e_err;
					ld_done = 1'b1;
				end else begin
					phase_d     = PH_SEEK_RD;
					row_d       = adv_row;
					plane_d     = adv_plane;
					row_off_d   = adv_off;
					held_emit_d = e_emit;
					held_addr_d = e_addr;
					held_val_d  = e_val;
					held_fill_d = e_fill;
					held_err_d  = e_err;
				end
			end else if (e_emit) begin
				ld      = 1'b1;
				ld_addr = e_addr;
				ld_val  = e_val;
				ld_fill = e_fill;
				ld_err  = e_err;
			end
		end else if (phase_q == PH_SEEK_RD) begin
			// Issue the read of the current row length.
			mem_re  = 1'b1;
			phase_d = PH_SEEK_CHK;
		end else if (phase_q == PH_SEEK_CHK && can_emit) begin
			// Examine one row length; skip zero-length rows one per cycle while the output can take a result.
			if (rd_len_q != '0) begin
				phase_d    = PH_DATA;
				row_left_d = rd_len_q;
				wr_addr_d  = row_off_q + channel;
				if (held_emit_q) begin
					ld      = 1'b1;
					ld_addr = held_addr_q;
					ld_val  = held_val_q;
					ld_fill = held_fill_q;
					ld_err  = held_err_q;
				end
			end else if (adv_done) begin
				phase_d = PH_DONE;
				ld      = 1'b1;
				ld_addr = held_addr_q;
				ld_val  = held_val_q;
				ld_fill = held_fill_q;
				ld_err  = held_err_q;
				ld_done = 1'b1;
			end else begin
				row_d     = adv_row;
				plane_d   = adv_plane;
				row_off_d = adv_off;
				mem_re    = 1'b1;
				mem_ra    = tbl_addr(adv_plane, adv_row);
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hdr_odd_q   <= 1'b0;
			hdr_row_q   <= '0;
			hdr_plane_q <= '0;
			len_hi_q    <= '0;
			plane_q     <= '0;
			row_q       <= '0;
			row_off_q   <= '0;
			wr_addr_q   <= '0;
			row_left_q  <= '0;
			lit_left_q  <= '0;
			pend_fill_q <= '0;
			held_emit_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			hdr_odd_q   <= hdr_odd_d;
			hdr_row_q   <= hdr_row_d;
			hdr_plane_q <= hdr_plane_d;
			len_hi_q    <= len_hi_d;
			plane_q     <= plane_d;
			row_q       <= row_d;
			row_off_q   <= row_off_d;
			wr_addr_q   <= wr_addr_d;
			row_left_q  <= row_left_d;
			lit_left_q  <= lit_left_d;
			pend_fill_q <= pend_fill_d;
			held_emit_q <= held_emit_d;
		end
	end

	// Held result payload.
	always_ff @(posedge clk) begin
		held_addr_q <= held_addr_d;
		held_val_q  <= held_val_d;
		held_fill_q <= held_fill_d;
		held_err_q  <= held_err_d;
	end

	// Row-length memory with a registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_len_q <= tbl_mem[mem_ra];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ld) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_addr_q <= ld_addr;
			out_val_q  <= ld_val;
			out_fill_q <= ld_fill;
			out_done_q <= ld_done;
			out_err_q  <= ld_err;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_fill_q, out_val_q, out_addr_q};
	assign m_tlast  = out_done_q;
	assign m_tuser  = out_err_q;

`ifndef SYNTHESIS
	// No byte is taken while a row length is being looked up.
	a_no_accept_in_seek: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SEEK_RD || phase_q == PH_SEEK_CHK) |-> !s_tready)
		else $error("byte accepted during row-length lookup");

	// A literal run and a repeat are never open at the same time.
	a_one_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		!(lit_left_q != '0 && pend_fill_q != '0))
		else $error("literal and repeat runs both open");

	// The frame-end result leaves only after the decoder has reached its done phase.
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |-> (phase_q == PH_DONE))
		else $error("frame end reported outside done phase");

	// While run data is taken, the row still has bytes left or a run is still open.
	a_data_row_open: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (row_left_q != '0 || lit_left_q != '0 || pend_fill_q != '0))
		else $error("run data phase with nothing left in the row");
`endif

endmodule
